// ----- sv/itpsl_pkg.sv -----
// ----------------------------------------------------------------------------
// itpsl_pkg
// Types, codes and constants shared by the power state ladder files.
// ----------------------------------------------------------------------------
package itpsl_pkg;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned LEVEL_WIDTH     = 3;
   localparam int unsigned SCAN_WIDTH      = 6;
   localparam int unsigned CSR_INDEX_WIDTH = 8;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ACTIVITY = 2'd1,
      OP_FORCE    = 2'd2,
      OP_CONSUME  = 2'd3
   } op_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIM_AFTER         = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_AFTER        = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_SLEEP_AFTER = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEEP_SLEEP_AFTER  = 8'd3;

   // Level codes as they appear on the result channel.
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_ACTIVE = 3'd0;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_DIM    = 3'd1;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_IDLE   = 3'd2;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_LIGHT  = 3'd3;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_DEEP   = 3'd4;

   // Scan intervals in milliseconds for each level.
   localparam logic [SCAN_WIDTH-1:0] SCAN_ACTIVE_MS = 6'd1;
   localparam logic [SCAN_WIDTH-1:0] SCAN_DIM_MS    = 6'd1;
   localparam logic [SCAN_WIDTH-1:0] SCAN_IDLE_MS   = 6'd20;
   localparam logic [SCAN_WIDTH-1:0] SCAN_LIGHT_MS  = 6'd50;
   localparam logic [SCAN_WIDTH-1:0] SCAN_DEEP_MS   = 6'd0;

   // Ladder state, one-hot.
   typedef enum logic [4:0] {
      ST_ACTIVE = 5'b00001,
      ST_DIM    = 5'b00010,
      ST_IDLE   = 5'b00100,
      ST_LIGHT  = 5'b01000,
      ST_DEEP   = 5'b10000
   } level_state_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] dim_after;
      logic [TIME_WIDTH-1:0] idle_after;
      logic [TIME_WIDTH-1:0] light_sleep_after;
      logic [TIME_WIDTH-1:0] deep_sleep_after;
   } thresholds_type;

   typedef struct packed {
      op_type                 op;
      logic [TIME_WIDTH-1:0]  now_ms;
      logic [LEVEL_WIDTH-1:0] forced_level;
   } item_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic [LEVEL_WIDTH-1:0] prior_level;
      logic                   changed;
      logic                   woke;
      logic [SCAN_WIDTH-1:0]  scan_period;
      logic                   halt_hint;
   } result_type;

   function automatic logic [LEVEL_WIDTH-1:0] level_code(input level_state_type st);
      logic [LEVEL_WIDTH-1:0] code;
      unique case (st)
         ST_ACTIVE: code = LEVEL_ACTIVE;
         ST_DIM:    code = LEVEL_DIM;
         ST_IDLE:   code = LEVEL_IDLE;
         ST_LIGHT:  code = LEVEL_LIGHT;
         default:   code = LEVEL_DEEP;
      endcase
      return code;
   endfunction

   // Codes above deep sleep saturate to deep sleep.
   function automatic level_state_type level_state(input logic [LEVEL_WIDTH-1:0] code);
      level_state_type st;
      unique case (code)
         LEVEL_ACTIVE: st = ST_ACTIVE;
         LEVEL_DIM:    st = ST_DIM;
         LEVEL_IDLE:   st = ST_IDLE;
         LEVEL_LIGHT:  st = ST_LIGHT;
         default:      st = ST_DEEP;
      endcase
      return st;
   endfunction

   function automatic logic [SCAN_WIDTH-1:0] scan_period(input level_state_type st);
      logic [SCAN_WIDTH-1:0] period;
      unique case (st)
         ST_ACTIVE: period = SCAN_ACTIVE_MS;
         ST_DIM:    period = SCAN_DIM_MS;
         ST_IDLE:   period = SCAN_IDLE_MS;
         ST_LIGHT:  period = SCAN_LIGHT_MS;
         default:   period = SCAN_DEEP_MS;
      endcase
      return period;
   endfunction

endpackage

// ----- sv/itpsl_channels_if.sv -----
// ----------------------------------------------------------------------------
// itpsl channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface itpsl_req_if;
   logic                                valid;
   logic                                ready;
   itpsl_pkg::op_type                   op;
   logic [itpsl_pkg::TIME_WIDTH-1:0]    now_ms;
   logic [itpsl_pkg::LEVEL_WIDTH-1:0]   forced_level;

   modport source (output valid, op, now_ms, forced_level, input ready);
   modport sink   (input valid, op, now_ms, forced_level, output ready);
endinterface

interface itpsl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [itpsl_pkg::LEVEL_WIDTH-1:0]   level;
   logic [itpsl_pkg::LEVEL_WIDTH-1:0]   prior_level;
   logic                                changed;
   logic                                woke;
   logic [itpsl_pkg::SCAN_WIDTH-1:0]    scan_period;
   logic                                halt_hint;

   modport source (output valid, level, prior_level, changed, woke, scan_period,
                   halt_hint, input ready);
   modport sink   (input valid, level, prior_level, changed, woke, scan_period,
                   halt_hint, output ready);
endinterface

interface itpsl_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [itpsl_pkg::CSR_INDEX_WIDTH-1:0]  reg_index;
   logic [itpsl_pkg::TIME_WIDTH-1:0]       wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- sv/itpsl_ladder.sv -----
// ----------------------------------------------------------------------------
// itpsl_ladder
// Ladder state, last activity time and wake flag, with the step logic.
// ----------------------------------------------------------------------------
module itpsl_ladder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  itpsl_pkg::item_type       item,
   input  itpsl_pkg::thresholds_type thresholds,
   output itpsl_pkg::result_type     result
);

   itpsl_pkg::level_state_type       level_ff, level_in;
   logic [itpsl_pkg::TIME_WIDTH-1:0] last_ff, last_in;
   logic                             wake_ff, wake_in;

   logic [itpsl_pkg::TIME_WIDTH-1:0] idle_ms;
   logic [itpsl_pkg::TIME_WIDTH-1:0] limit;
   itpsl_pkg::level_state_type       deeper;
   logic                             hit;
   logic                             woke;
   logic                             halt;

   // Threshold and next level of the step that a tick may take.
   always_comb begin
      unique case (level_ff)
         itpsl_pkg::ST_ACTIVE: begin
            limit  = thresholds.dim_after;
            deeper = itpsl_pkg::ST_DIM;
         end
         itpsl_pkg::ST_DIM: begin
            limit  = thresholds.idle_after;
            deeper = itpsl_pkg::ST_IDLE;
         end
         itpsl_pkg::ST_IDLE: begin
            limit  = thresholds.light_sleep_after;
            deeper = itpsl_pkg::ST_LIGHT;
         end
         itpsl_pkg::ST_LIGHT: begin
            limit  = thresholds.deep_sleep_after;
            deeper = itpsl_pkg::ST_DEEP;
         end
         default: begin
            limit  = '0;
            deeper = itpsl_pkg::ST_DEEP;
         end
      endcase
   end

   // Idle time wraps modulo 2^32; a zero threshold never fires.
   assign idle_ms = item.now_ms - last_ff;
   assign hit     = (limit != '0) && (idle_ms >= limit);

   always_comb begin
      level_in = level_ff;
      last_in  = last_ff;
      wake_in  = wake_ff;
      woke     = 1'b0;
      halt     = 1'b0;
      case (item.op)
         itpsl_pkg::OP_TICK: begin
            if (hit) begin
               level_in = deeper;
            end else if (level_ff == itpsl_pkg::ST_LIGHT) begin
               halt = 1'b1;
            end
         end
         itpsl_pkg::OP_ACTIVITY: begin
            last_in = item.now_ms;
            if (level_ff != itpsl_pkg::ST_ACTIVE) begin
               wake_in  = (level_ff == itpsl_pkg::ST_LIGHT) ||
                          (level_ff == itpsl_pkg::ST_DEEP);
               level_in = itpsl_pkg::ST_ACTIVE;
            end
         end
         itpsl_pkg::OP_FORCE: begin
            last_in  = item.now_ms - thresholds.deep_sleep_after;
            level_in = itpsl_pkg::level_state(item.forced_level);
         end
         default: begin
            woke    = wake_ff;
            wake_in = 1'b0;
         end
      endcase
   end

   assign result.level       = itpsl_pkg::level_code(level_in);
   assign result.prior_level = itpsl_pkg::level_code(level_ff);
   assign result.changed     = (level_in != level_ff);
   assign result.woke        = woke;
   assign result.scan_period = itpsl_pkg::scan_period(level_in);
   assign result.halt_hint   = halt;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= itpsl_pkg::ST_ACTIVE;
         last_ff  <= '0;
         wake_ff  <= 1'b0;
      end else if (step) begin
         level_ff <= level_in;
         last_ff  <= last_in;
         wake_ff  <= wake_in;
      end
   end

endmodule

// ----- sv/idle_timeout_power_state_ladder.sv -----
// ----------------------------------------------------------------------------
// idle_timeout_power_state_ladder
// Five-level idle timeout ladder: active, dim, idle, light and deep sleep.
//
//   Channel   Direction  Transfer carries
//   req_chan  in         op, now_ms, forced_level
//   rsp_chan  out        level, prior_level, changed, woke, scan_period,
//                        halt_hint
//   csr_chan  in         reg_index, wdata (threshold write, always ready)
//
// An item passes through the input register, and its result is written to the
// result register as the item leaves it. One item per cycle is sustained while
// rsp_chan takes results. The ladder state advances as the item leaves the input
// register, so items are handled strictly in order. A stalled result holds
// the input register, and req_chan.ready drops only when both are full.
// Synchronous reset returns the ladder to active with all thresholds zero.
// ----------------------------------------------------------------------------
module idle_timeout_power_state_ladder (
   input logic       clock,
   input logic       reset,
   itpsl_req_if.sink   req_chan,
   itpsl_rsp_if.source rsp_chan,
   itpsl_csr_if.sink   csr_chan
);

   itpsl_pkg::thresholds_type thresholds_ff;

   logic                  in_valid_ff;
   itpsl_pkg::item_type   in_item_ff;
   logic                  out_valid_ff;
   itpsl_pkg::result_type out_result_ff;

   itpsl_pkg::result_type result;
   logic                  out_free;
   logic                  step;

   // Register writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            itpsl_pkg::CSR_DIM_AFTER:         thresholds_ff.dim_after         <= csr_chan.wdata;
            itpsl_pkg::CSR_IDLE_AFTER:        thresholds_ff.idle_after        <= csr_chan.wdata;
            itpsl_pkg::CSR_LIGHT_SLEEP_AFTER: thresholds_ff.light_sleep_after <= csr_chan.wdata;
            itpsl_pkg::CSR_DEEP_SLEEP_AFTER:  thresholds_ff.deep_sleep_after  <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   // The result register frees when empty or when its transfer completes.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_item_ff.op           <= req_chan.op;
         in_item_ff.now_ms       <= req_chan.now_ms;
         in_item_ff.forced_level <= req_chan.forced_level;
      end
   end

   itpsl_ladder u_ladder (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .thresholds (thresholds_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_result_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.level       = out_result_ff.level;
   assign rsp_chan.prior_level = out_result_ff.prior_level;
   assign rsp_chan.changed     = out_result_ff.changed;
   assign rsp_chan.woke        = out_result_ff.woke;
   assign rsp_chan.scan_period = out_result_ff.scan_period;
   assign rsp_chan.halt_hint   = out_result_ff.halt_hint;

endmodule
